// ===== hw/rtl/velocity_estimator_lowpass_unit_assert.svh =====
// Assertion macros for the velocity estimator.
// Used by the checker file only; no other dependencies.
`ifndef VELOCITY_ESTIMATOR_LOWPASS_UNIT_ASSERT_SVH
`define VELOCITY_ESTIMATOR_LOWPASS_UNIT_ASSERT_SVH

// Clocked check, off while reset is held.
`define VELEST_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("velocity estimator check failed");

// Clocked check that also holds during reset.
`define VELEST_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("velocity estimator check failed");

`endif

// ===== hw/rtl/velest_pkg.sv =====
// Shared types and constants of the velocity estimator.
// No dependencies.
`default_nettype none

package velest_pkg;

  localparam int unsigned AFB       = 16;       // alpha fraction bits
  localparam int unsigned ALPHA_W   = AFB + 1;  // alpha may reach exactly 1.0
  localparam int unsigned SPD_Q_W   = 31;       // speed quotient stays below 2^31
  localparam int unsigned DIV_CNT_W = $clog2(SPD_Q_W + 1);
  localparam int unsigned POS_W     = 32;
  localparam int unsigned TIME_W    = 64;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned LIM_W     = 31;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned DVD_W     = 64;
  localparam int unsigned DVS_W     = 33;

  localparam logic [29:0] NS_PER_S = 30'd1000000000;
  localparam logic [1:0]  QUAL_GOOD = 2'd2;
  localparam logic [1:0]  AXIS_Z    = 2'd2;

  localparam logic [LIM_W-1:0] RST_MAX_H  = 31'd1310720;
  localparam logic [LIM_W-1:0] RST_MAX_V  = 31'd655360;
  localparam logic [CFG_W-1:0] RST_TAU_H  = 32'd100000000;
  localparam logic [CFG_W-1:0] RST_TAU_V  = 32'd150000000;
  localparam logic [CFG_W-1:0] RST_MIN_DT = 32'd5000000;
  localparam logic [CFG_W-1:0] RST_MAX_DT = 32'd200000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_H  = 3'd0,
    CFG_MAX_V  = 3'd1,
    CFG_TAU_H  = 3'd2,
    CFG_TAU_V  = 3'd3,
    CFG_MIN_DT = 3'd4,
    CFG_MAX_DT = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DT,
    OP_GATE,
    OP_MUL,
    OP_CHECK,
    OP_SDIV,
    OP_SSTORE,
    OP_ADIV,
    OP_ASTORE,
    OP_LPMUL,
    OP_LPUPD,
    OP_COMMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] axis;
    logic       sel;   // 0 horizontal, 1 vertical
  } dp_cmd_t;

  typedef struct packed {
    logic ok;
    logic have_filt;
    logic div_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/velest_div.sv =====
// Restoring divider, one quotient bit per cycle, for speed and alpha.
// Depends on velest_pkg.
`default_nettype none

module velest_div (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic                                long_i,
  input  wire logic [velest_pkg::DVD_W-1:0]        dividend_i,
  input  wire logic [velest_pkg::DVS_W-1:0]        divisor_i,
  output logic                                     busy_o,
  output logic [velest_pkg::SPD_Q_W-1:0]           quo_o
);

  logic                              busy_q, busy_d;
  logic [velest_pkg::DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [velest_pkg::DVS_W-1:0]      rem_q, rem_d;
  logic [velest_pkg::DVS_W-1:0]      dvs_q, dvs_d;
  logic [velest_pkg::DVD_W-1:0]      dvd_q, dvd_d;
  logic [velest_pkg::DVS_W:0]        trial;
  logic [velest_pkg::DVS_W:0]        diff;
  logic                              ge;
  logic [velest_pkg::DVD_W-1:0]      rem_long, rem_short;

  assign rem_long  = dividend_i >> velest_pkg::SPD_Q_W;
  assign rem_short = dividend_i >> velest_pkg::ALPHA_W;
  assign trial     = {rem_q, dvd_q[velest_pkg::DVD_W-1]};
  assign diff      = trial - {1'b0, dvs_q};
  assign ge        = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    dvd_d  = dvd_q;
    if (start_i) begin
      busy_d = 1'b1;
      dvs_d  = divisor_i;
      // quotient bit count is known for each use, so the top of the dividend
      // starts out as the partial remainder
      if (long_i) begin
        cnt_d = velest_pkg::DIV_CNT_W'(velest_pkg::SPD_Q_W);
        rem_d = rem_long[velest_pkg::DVS_W-1:0];
        dvd_d = dividend_i << (velest_pkg::DVD_W - velest_pkg::SPD_Q_W);
      end else begin
        cnt_d = velest_pkg::DIV_CNT_W'(velest_pkg::ALPHA_W);
        rem_d = rem_short[velest_pkg::DVS_W-1:0];
        dvd_d = dividend_i << (velest_pkg::DVD_W - velest_pkg::ALPHA_W);
      end
    end else if (busy_q) begin
      rem_d = ge ? diff[velest_pkg::DVS_W-1:0] : trial[velest_pkg::DVS_W-1:0];
      dvd_d = {dvd_q[velest_pkg::DVD_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == velest_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    dvd_q <= dvd_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = dvd_q[velest_pkg::SPD_Q_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/velest_dp.sv =====
// Datapath: configuration, sample history, speed checks, filter update.
// Depends on velest_pkg and velest_div.
`default_nettype none

module velest_dp (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [velest_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [velest_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  wire logic signed [velest_pkg::POS_W-1:0]   pos_x_i,
  input  wire logic signed [velest_pkg::POS_W-1:0]   pos_y_i,
  input  wire logic signed [velest_pkg::POS_W-1:0]   pos_z_i,
  input  wire logic signed [velest_pkg::TIME_W-1:0]  sample_time_ns_i,
  input  wire logic [1:0]                            pose_quality_i,
  input  wire logic [15:0]                           map_reset_count_i,
  input  wire velest_pkg::dp_cmd_t                   cmd_i,
  output velest_pkg::dp_stat_t                       stat_o,
  output logic                                       vel_valid_o,
  output logic signed [velest_pkg::POS_W-1:0]        vel_x_o,
  output logic signed [velest_pkg::POS_W-1:0]        vel_y_o,
  output logic signed [velest_pkg::POS_W-1:0]        vel_z_o
);

  localparam int unsigned LPM_W = velest_pkg::DVS_W + velest_pkg::ALPHA_W;
  localparam int unsigned STEP_W = LPM_W - velest_pkg::AFB;

  // configuration
  logic [velest_pkg::LIM_W-1:0] max_h_q, max_v_q;
  logic [velest_pkg::CFG_W-1:0] tau_h_q, tau_v_q, min_dt_q, max_dt_q;

  // current sample
  logic [velest_pkg::POS_W-1:0]  in_pos_q [3];
  logic [velest_pkg::TIME_W-1:0] in_time_q;
  logic [1:0]                    in_qual_q;
  logic [15:0]                   in_mc_q;

  // history and filter
  logic [velest_pkg::POS_W-1:0]  prev_pos_q [3];
  logic [velest_pkg::TIME_W-1:0] prev_time_q;
  logic [1:0]                    prev_qual_q;
  logic [15:0]                   prev_mc_q;
  logic                          have_prev_q, have_filt_q;
  logic [velest_pkg::POS_W-1:0]  filt_q [3];

  // working registers
  logic [velest_pkg::TIME_W-1:0]  dt_q;
  logic                           gate_q, ok_q, neg_q, lp_neg_q;
  logic [62:0]                    num_q, limdt_q;
  logic [velest_pkg::POS_W-1:0]   raw_q [3];
  logic [velest_pkg::ALPHA_W-1:0] alpha_q [2];
  logic [LPM_W-1:0]               lp_m_q;

  logic                           vel_valid_q;
  logic [velest_pkg::POS_W-1:0]   vel_q [3];

  // combinational helpers
  logic [velest_pkg::CFG_W-1:0]   dt32;
  logic [velest_pkg::DVS_W-1:0]   d, d_mag, lpd, lpd_mag;
  logic [velest_pkg::LIM_W-1:0]   lim;
  logic [velest_pkg::CFG_W-1:0]   tau;
  logic                           div_start, div_long, div_busy;
  logic [velest_pkg::DVD_W-1:0]   div_dvd;
  logic [velest_pkg::DVS_W-1:0]   div_dvs;
  logic [velest_pkg::SPD_Q_W-1:0] quo;
  logic [STEP_W-1:0]              step;
  logic [STEP_W-1:0]              f_ext, f_new;
  logic [velest_pkg::POS_W-1:0]   pos_a, prev_a, raw_a, filt_a;
  logic [velest_pkg::ALPHA_W-1:0] alpha_a;
  logic                           gate_d, win_ok;

  assign dt32    = dt_q[velest_pkg::CFG_W-1:0];
  assign pos_a   = in_pos_q[cmd_i.axis];
  assign prev_a  = prev_pos_q[cmd_i.axis];
  assign raw_a   = raw_q[cmd_i.axis];
  assign filt_a  = filt_q[cmd_i.axis];
  assign alpha_a = alpha_q[cmd_i.axis == velest_pkg::AXIS_Z];
  assign lim     = (cmd_i.axis == velest_pkg::AXIS_Z) ? max_v_q : max_h_q;
  assign tau     = cmd_i.sel ? tau_v_q : tau_h_q;

  assign d       = {pos_a[velest_pkg::POS_W-1], pos_a} - {prev_a[velest_pkg::POS_W-1], prev_a};
  assign d_mag   = d[velest_pkg::DVS_W-1] ? -d : d;
  assign lpd     = {raw_a[velest_pkg::POS_W-1], raw_a} - {filt_a[velest_pkg::POS_W-1], filt_a};
  assign lpd_mag = lpd[velest_pkg::DVS_W-1] ? -lpd : lpd;

  assign step  = STEP_W'((lp_m_q + (LPM_W'(1) << (velest_pkg::AFB - 1))) >> velest_pkg::AFB);
  assign f_ext = {{(STEP_W - velest_pkg::POS_W){filt_a[velest_pkg::POS_W-1]}}, filt_a};
  assign f_new = lp_neg_q ? f_ext - step : f_ext + step;

  assign gate_d = (in_qual_q == velest_pkg::QUAL_GOOD) && have_prev_q &&
                  (prev_qual_q == velest_pkg::QUAL_GOOD) && (in_mc_q == prev_mc_q) &&
                  ($signed(in_time_q) > $signed(prev_time_q));
  assign win_ok = (dt_q >= {32'd0, min_dt_q}) && (dt_q <= {32'd0, max_dt_q});

  assign div_start = (cmd_i.op == velest_pkg::OP_SDIV) || (cmd_i.op == velest_pkg::OP_ADIV);
  assign div_long  = (cmd_i.op == velest_pkg::OP_SDIV);
  assign div_dvd   = div_long ? {1'b0, num_q}
                              : velest_pkg::DVD_W'({dt32, {velest_pkg::AFB{1'b0}}});
  assign div_dvs   = div_long ? {1'b0, dt32} : {1'b0, tau} + {1'b0, dt32};

  velest_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .long_i     (div_long),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .quo_o      (quo)
  );

  // control-side state: config, history flags, filter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_h_q     <= velest_pkg::RST_MAX_H;
      max_v_q     <= velest_pkg::RST_MAX_V;
      tau_h_q     <= velest_pkg::RST_TAU_H;
      tau_v_q     <= velest_pkg::RST_TAU_V;
      min_dt_q    <= velest_pkg::RST_MIN_DT;
      max_dt_q    <= velest_pkg::RST_MAX_DT;
      have_prev_q <= 1'b0;
      have_filt_q <= 1'b0;
      prev_time_q <= '0;
      prev_qual_q <= '0;
      prev_mc_q   <= '0;
      ok_q        <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        prev_pos_q[i] <= '0;
        filt_q[i]     <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          velest_pkg::CFG_MAX_H:  max_h_q  <= cfg_wdata_i[velest_pkg::LIM_W-1:0];
          velest_pkg::CFG_MAX_V:  max_v_q  <= cfg_wdata_i[velest_pkg::LIM_W-1:0];
          velest_pkg::CFG_TAU_H:  tau_h_q  <= cfg_wdata_i;
          velest_pkg::CFG_TAU_V:  tau_v_q  <= cfg_wdata_i;
          velest_pkg::CFG_MIN_DT: min_dt_q <= cfg_wdata_i;
          velest_pkg::CFG_MAX_DT: max_dt_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      unique case (cmd_i.op)
        velest_pkg::OP_GATE:  ok_q <= gate_q && win_ok;
        velest_pkg::OP_CHECK: begin
          if (num_q > limdt_q) begin
            ok_q <= 1'b0;
          end
        end
        velest_pkg::OP_LPUPD: filt_q[cmd_i.axis] <= f_new[velest_pkg::POS_W-1:0];
        velest_pkg::OP_COMMIT: begin
          for (int i = 0; i < 3; i++) begin
            prev_pos_q[i] <= in_pos_q[i];
          end
          prev_time_q <= in_time_q;
          prev_qual_q <= in_qual_q;
          prev_mc_q   <= in_mc_q;
          have_prev_q <= 1'b1;
          if (!ok_q) begin
            have_filt_q <= 1'b0;
            for (int i = 0; i < 3; i++) begin
              filt_q[i] <= '0;
            end
          end else if (!have_filt_q) begin
            have_filt_q <= 1'b1;
            for (int i = 0; i < 3; i++) begin
              filt_q[i] <= raw_q[i];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      velest_pkg::OP_LOAD: begin
        in_pos_q[0] <= pos_x_i;
        in_pos_q[1] <= pos_y_i;
        in_pos_q[2] <= pos_z_i;
        in_time_q   <= sample_time_ns_i;
        in_qual_q   <= pose_quality_i;
        in_mc_q     <= map_reset_count_i;
      end
      velest_pkg::OP_DT: begin
        dt_q   <= in_time_q - prev_time_q;
        gate_q <= gate_d;
      end
      velest_pkg::OP_MUL: begin
        neg_q   <= d[velest_pkg::DVS_W-1];
        num_q   <= 63'(d_mag * velest_pkg::NS_PER_S);
        limdt_q <= 63'(lim * dt32);
      end
      velest_pkg::OP_SSTORE: begin
        raw_q[cmd_i.axis] <= neg_q ? -{1'b0, quo} : {1'b0, quo};
      end
      velest_pkg::OP_ASTORE: alpha_q[cmd_i.sel] <= quo[velest_pkg::ALPHA_W-1:0];
      velest_pkg::OP_LPMUL: begin
        lp_neg_q <= lpd[velest_pkg::DVS_W-1];
        lp_m_q   <= lpd_mag * alpha_a;
      end
      velest_pkg::OP_COMMIT: begin
        vel_valid_q <= ok_q;
        for (int i = 0; i < 3; i++) begin
          if (!ok_q) begin
            vel_q[i] <= '0;
          end else begin
            vel_q[i] <= have_filt_q ? filt_q[i] : raw_q[i];
          end
        end
      end
      default: ;
    endcase
  end

  assign stat_o.ok        = ok_q;
  assign stat_o.have_filt = have_filt_q;
  assign stat_o.div_busy  = div_busy;

  assign vel_valid_o = vel_valid_q;
  assign vel_x_o     = vel_q[0];
  assign vel_y_o     = vel_q[1];
  assign vel_z_o     = vel_q[2];

endmodule

`default_nettype wire

// ===== hw/rtl/velest_ctrl.sv =====
// Sequencer: steps the datapath through checks, divisions and filter update.
// Depends on velest_pkg.
`default_nettype none

module velest_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  input  wire velest_pkg::dp_stat_t  stat_i,
  output velest_pkg::dp_cmd_t        cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DT, S_GATE, S_MUL, S_CHECK, S_SDIV, S_SWAIT,
    S_ADIV, S_AWAIT, S_LPMUL, S_LPUPD, S_FIN
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] axis_q, axis_d;
  logic       sel_q, sel_d;
  logic       out_valid_q, out_valid_d;
  velest_pkg::dp_op_e op;

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    sel_d   = sel_q;
    op      = velest_pkg::OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op      = velest_pkg::OP_LOAD;
          state_d = S_DT;
        end
      end
      S_DT: begin
        op      = velest_pkg::OP_DT;
        state_d = S_GATE;
      end
      S_GATE: begin
        op      = velest_pkg::OP_GATE;
        axis_d  = '0;
        state_d = S_MUL;
      end
      S_MUL: begin
        if (!stat_i.ok) begin
          state_d = S_FIN;
        end else begin
          op      = velest_pkg::OP_MUL;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        op      = velest_pkg::OP_CHECK;
        state_d = S_SDIV;
      end
      S_SDIV: begin
        if (!stat_i.ok) begin
          state_d = S_FIN;
        end else begin
          op      = velest_pkg::OP_SDIV;
          state_d = S_SWAIT;
        end
      end
      S_SWAIT: begin
        if (!stat_i.div_busy) begin
          op = velest_pkg::OP_SSTORE;
          if (axis_q == velest_pkg::AXIS_Z) begin
            // first good pair seeds the filter directly
            if (stat_i.have_filt) begin
              sel_d   = 1'b0;
              state_d = S_ADIV;
            end else begin
              state_d = S_FIN;
            end
          end else begin
            axis_d  = axis_q + 1'b1;
            state_d = S_MUL;
          end
        end
      end
      S_ADIV: begin
        op      = velest_pkg::OP_ADIV;
        state_d = S_AWAIT;
      end
      S_AWAIT: begin
        if (!stat_i.div_busy) begin
          op = velest_pkg::OP_ASTORE;
          if (sel_q) begin
            axis_d  = '0;
            state_d = S_LPMUL;
          end else begin
            sel_d   = 1'b1;
            state_d = S_ADIV;
          end
        end
      end
      S_LPMUL: begin
        op      = velest_pkg::OP_LPMUL;
        state_d = S_LPUPD;
      end
      S_LPUPD: begin
        op = velest_pkg::OP_LPUPD;
        if (axis_q == velest_pkg::AXIS_Z) begin
          state_d = S_FIN;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = S_LPMUL;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          op      = velest_pkg::OP_COMMIT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (op == velest_pkg::OP_COMMIT) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= '0;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o.op    = op;
  assign cmd_o.axis  = axis_q;
  assign cmd_o.sel   = sel_q;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/velocity_estimator_lowpass_unit.sv =====
// Velocity estimator top level: one pose sample in, one velocity request out.
// Works on one sample at a time. A sample that fails the quality, map-count,
// time or window checks finishes without a division; a sample whose speeds
// are checked and that seeds the filter runs the three speed divisions, and
// one that also updates the filter runs the two filter-gain divisions too.
// The shared divider produces one quotient bit per cycle: 31 bits for each
// of the three axis speeds and 17 for each of the two filter gains. A
// finished result sits in the output register while the next sample is taken
// in; a result still waiting there holds the following one in its last
// cycle. Depends on velest_pkg, velest_ctrl, velest_dp and velest_div.
`default_nettype none

module velocity_estimator_lowpass_unit (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [velest_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [velest_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic signed [velest_pkg::POS_W-1:0]   pos_x_i,
  input  wire logic signed [velest_pkg::POS_W-1:0]   pos_y_i,
  input  wire logic signed [velest_pkg::POS_W-1:0]   pos_z_i,
  input  wire logic signed [velest_pkg::TIME_W-1:0]  sample_time_ns_i,
  input  wire logic [1:0]                            pose_quality_i,
  input  wire logic [15:0]                           map_reset_count_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic                                       vel_valid_o,
  output logic signed [velest_pkg::POS_W-1:0]        vel_x_o,
  output logic signed [velest_pkg::POS_W-1:0]        vel_y_o,
  output logic signed [velest_pkg::POS_W-1:0]        vel_z_o
);

  velest_pkg::dp_cmd_t  cmd;
  velest_pkg::dp_stat_t stat;

  velest_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  velest_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .pos_x_i           (pos_x_i),
    .pos_y_i           (pos_y_i),
    .pos_z_i           (pos_z_i),
    .sample_time_ns_i  (sample_time_ns_i),
    .pose_quality_i    (pose_quality_i),
    .map_reset_count_i (map_reset_count_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .vel_valid_o       (vel_valid_o),
    .vel_x_o           (vel_x_o),
    .vel_y_o           (vel_y_o),
    .vel_z_o           (vel_z_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/velest_checker.sv =====
// Port-level checks of the velocity estimator, bound to the top level.
// Depends on velest_pkg and velocity_estimator_lowpass_unit_assert.svh.
`default_nettype none

`include "velocity_estimator_lowpass_unit_assert.svh"

module velest_checker (
  input wire logic                                  clk_i,
  input wire logic                                  rst_ni,
  input wire logic                                  in_valid_i,
  input wire logic                                  in_ready_o,
  input wire logic                                  out_valid_o,
  input wire logic                                  out_ready_i,
  input wire logic                                  vel_valid_o,
  input wire logic signed [velest_pkg::POS_W-1:0]   vel_x_o,
  input wire logic signed [velest_pkg::POS_W-1:0]   vel_y_o,
  input wire logic signed [velest_pkg::POS_W-1:0]   vel_z_o
);

  // a stalled result request holds
  `VELEST_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o)
  `VELEST_ASSERT(a_out_stable, out_valid_o && !out_ready_i |=> $stable({vel_valid_o, vel_x_o, vel_y_o, vel_z_o}))
  // invalid estimate reports zero velocity
  `VELEST_ASSERT(a_invalid_zero, out_valid_o && !vel_valid_o |-> vel_x_o == '0 && vel_y_o == '0 && vel_z_o == '0)
  // one sample in flight at a time
  `VELEST_ASSERT(a_one_in_flight, in_valid_i && in_ready_o |=> !in_ready_o)
  `VELEST_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o || $past(rst_ni))

endmodule

bind velocity_estimator_lowpass_unit velest_checker u_velest_checker (.*);

`default_nettype wire
